>>> rtl/core/tcp_window_with_hybrid_slow_start_defines.svh
// assertion macros for the window block
`ifndef TCP_WINDOW_WITH_HYBRID_SLOW_START_DEFINES_SVH
`define TCP_WINDOW_WITH_HYBRID_SLOW_START_DEFINES_SVH

`ifndef ASSERT_OFF
`define TWHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TWHS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TWHS_ASSERT(lbl, prop, msg)
`define TWHS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/core/twhs_pkg.sv
package twhs_pkg;

  localparam int unsigned TimeW = 48;
  localparam int unsigned RttW  = 24;
  localparam int unsigned SegW  = 16;
  localparam int unsigned WinW  = 32;
  localparam int unsigned DvdW  = 35;
  localparam int unsigned CntW  = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [RttW-1:0] RttAllOnes = {RttW{1'b1}};

  // ceil(2^34 / 5), exact floor(x / 5) for any 32-bit x after a shift by 34
  localparam logic [WinW-1:0] RecipFive = 32'hCCCC_CCCD;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLE    = 3'd0,
    REG_LOW_WIN   = 3'd1,
    REG_MIN_SAMP  = 3'd2,
    REG_TRAIN_GAP = 3'd3,
    REG_CLAMP_LO  = 3'd4,
    REG_CLAMP_HI  = 3'd5,
    REG_SEG       = 3'd6,
    REG_NONE      = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE, S_LOSS, S_MUL0, S_MUL1, S_MUL2, S_HYS, S_DIV, S_FIN
  } state_e;

  typedef enum logic [1:0] {
    MODE_NONE, MODE_SS, MODE_CA, MODE_SQ
  } mode_e;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [WinW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DvdW-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/core/twhs_div.sv
module twhs_div
  import twhs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned StepW = $clog2(DvdW + 1);

  logic [DvdW-1:0]  quo_q, quo_d;
  logic [WinW:0]    rem_q, rem_d;
  logic [WinW-1:0]  dsr_q, dsr_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [WinW:0]    trial;
  logic [WinW:0]    diff;

  always_comb begin
    trial  = {rem_q[WinW-1:0], quo_q[DvdW-1]};
    diff   = trial - {1'b0, dsr_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      step_d = StepW'(DvdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = diff;
        quo_d = {quo_q[DvdW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DvdW-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> rtl/core/tcp_window_with_hybrid_slow_start.sv
// tcp congestion window update with hybrid slow start exit detection
// input channel s_axis: one word per ack or loss event; tuser selects the kind
// (0 ack with rtt sample, 1 loss). output channel m_axis: one result word per
// input word, carrying the new window and threshold, tuser flags a slow start exit.
// configuration: cfg_we_i with cfg_idx_i/cfg_wdata_i writes one register per cycle;
// the user must write only while no word is in progress, the block does not enforce it.
// path to the output register: a loss word passes the loss and finish steps; an ack
// word in slow start or without an avoidance division passes the multiply steps,
// the hybrid slow start step and the finish step; an avoidance increment adds a wait
// in the radix-2 divider, one quotient bit per cycle over 35 bits, before finishing.
// one 16x16 multiplier is reused in the steps S_MUL0, S_MUL1 and S_MUL2 for the products of the
// segment size; the six fifths slow start growth uses a reciprocal multiply.
// the block takes one word at a time: s_axis_tready is high only when idle.
// a finished result sits in the output register while the next word is taken;
// if the receiver stalls, the following result waits in the last step until the
// output register frees up.
// reset clears the hybrid slow start state (round minimum to all ones) and loads
// the register defaults.
`include "tcp_window_with_hybrid_slow_start_defines.svh"
module tcp_window_with_hybrid_slow_start
  import twhs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [RttW-1:0]      cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // now_us, rtt_us, segments_acked, cwnd_in, ssthresh_in, acked_seq,
  // highest_sent_seq, bytes_in_flight
  input  logic [247:0]         s_axis_tdata,
  // op
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // cwnd_out, ssthresh_out
  output logic [63:0]          m_axis_tdata,
  // slow_start_exit
  output logic                 m_axis_tuser
);

  // configuration
  logic            en_q;
  logic [SegW-1:0] low_q, seg_q;
  logic [CntW-1:0] msamp_q;
  logic [RttW-1:0] gap_q, clo_q, chi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b1;
      low_q   <= SegW'(16);
      msamp_q <= CntW'(32);
      gap_q   <= RttW'(2000);
      clo_q   <= RttW'(8000);
      chi_q   <= RttW'(1024000);
      seg_q   <= SegW'(536);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ENABLE:    en_q    <= cfg_wdata_i[0];
        REG_LOW_WIN:   low_q   <= cfg_wdata_i[SegW-1:0];
        REG_MIN_SAMP:  msamp_q <= cfg_wdata_i[CntW-1:0];
        REG_TRAIN_GAP: gap_q   <= cfg_wdata_i;
        REG_CLAMP_LO:  clo_q   <= cfg_wdata_i;
        REG_CLAMP_HI:  chi_q   <= cfg_wdata_i;
        REG_SEG:       seg_q   <= cfg_wdata_i[SegW-1:0];
        default: ;
      endcase
    end
  end

  // input word
  logic             op_q;
  logic [TimeW-1:0] now_q;
  logic [RttW-1:0]  rtt_q;
  logic [SegW-1:0]  ack_q;
  logic [WinW-1:0]  cwnd_q, ssth_q, aseq_q, hseq_q, fl_q;

  state_e state_q, state_d;
  logic   accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= s_axis_tuser;
      now_q  <= s_axis_tdata[47:0];
      rtt_q  <= s_axis_tdata[71:48];
      ack_q  <= s_axis_tdata[87:72];
      cwnd_q <= s_axis_tdata[119:88];
      ssth_q <= s_axis_tdata[151:120];
      aseq_q <= s_axis_tdata[183:152];
      hseq_q <= s_axis_tdata[215:184];
      fl_q   <= s_axis_tdata[247:216];
    end
  end

  // shared multiplier
  logic [SegW-1:0]   mul_a;
  logic [WinW-1:0]   mul_p;
  logic [WinW-1:0]   lowseg_q, sq_q, ab_q;
  logic [2*WinW-1:0] recip_p;
  logic [WinW-1:0]   fifth_q;
  assign mul_p   = WinW'(mul_a) * WinW'(seg_q);
  assign recip_p = (2*WinW)'(ab_q) * (2*WinW)'(RecipFive);

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL0) lowseg_q <= mul_p;
    if (state_q == S_MUL1) sq_q     <= mul_p;
    if (state_q == S_MUL2) ab_q     <= mul_p;
    if (state_q == S_HYS)  fifth_q  <= {2'b00, recip_p[2*WinW-1:WinW+2]};
  end

  // hybrid slow start state
  logic [RttW-1:0]  mrtt_q, rmin_q;
  logic             mrv_q, exit_q;
  logic [TimeW-1:0] rstart_q, train_q;
  logic [CntW-1:0]  cnt_q;
  logic [WinW-1:0]  rend_q;

  logic [RttW-1:0]  mr, thr;
  logic [RttW:0]    mr_thr;
  logic [TimeW-1:0] dt_train, dt_round;
  logic             elig, train_ok, found_t, samp, found_d, found, ss, new_rnd;
  logic [WinW-1:0]  ssth_e, dseq;
  logic             need_div;

  always_comb begin
    mr       = (!mrv_q || (mrtt_q > rtt_q)) ? rtt_q : mrtt_q;
    elig     = en_q && (cwnd_q <= ssth_q) && (cwnd_q >= lowseg_q) && !exit_q;
    dt_train = now_q - train_q;
    dt_round = now_q - rstart_q;
    train_ok = dt_train <= TimeW'(gap_q);
    found_t  = train_ok && (dt_round > TimeW'(mr));
    samp     = cnt_q < msamp_q;
    if (mr > chi_q) begin
      thr = chi_q;
    end else if (mr < clo_q) begin
      thr = clo_q;
    end else begin
      thr = mr;
    end
    mr_thr   = {1'b0, mr} + {1'b0, thr};
    found_d  = !samp && ({1'b0, rmin_q} > mr_thr);
    found    = elig && (found_t || found_d);
    ssth_e   = found ? cwnd_q : ssth_q;
    ss       = cwnd_q < ssth_e;
    dseq     = aseq_q - rend_q;
    new_rnd  = ss && en_q && (dseq != '0) && !dseq[WinW-1];
    need_div = !ss && (ack_q != '0) && (cwnd_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mrtt_q   <= '0;
      mrv_q    <= 1'b0;
      rstart_q <= '0;
      train_q  <= '0;
      rmin_q   <= RttAllOnes;
      cnt_q    <= '0;
      exit_q   <= 1'b0;
      rend_q   <= '0;
    end else if (state_q == S_LOSS) begin
      mrtt_q   <= '0;
      mrv_q    <= 1'b0;
      rstart_q <= now_q;
      train_q  <= now_q;
      rmin_q   <= RttAllOnes;
      cnt_q    <= '0;
      exit_q   <= 1'b0;
      rend_q   <= hseq_q;
    end else if (state_q == S_HYS) begin
      mrtt_q <= mr;
      mrv_q  <= 1'b1;
      if (new_rnd) begin
        rstart_q <= now_q;
        train_q  <= now_q;
        rmin_q   <= RttAllOnes;
        cnt_q    <= '0;
        exit_q   <= 1'b0;
        rend_q   <= hseq_q;
      end else if (elig) begin
        if (train_ok) train_q <= now_q;
        if (samp) begin
          if (rtt_q < rmin_q) rmin_q <= rtt_q;
          cnt_q <= cnt_q + 1'b1;
        end
        if (found) exit_q <= 1'b1;
      end
    end
  end

  // result staging
  mode_e           mode_q;
  logic [WinW-1:0] rssth_q;
  logic            rexit_q;
  logic [SegW+1:0] three;
  logic [WinW-1:0] half;

  assign three = {seg_q, 1'b0} + {2'b00, seg_q};
  assign half  = {1'b0, fl_q[WinW-1:1]};

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOSS) begin
      mode_q  <= MODE_NONE;
      rexit_q <= 1'b0;
      rssth_q <= (WinW'(three) > half) ? WinW'(three) : half;
    end else if (state_q == S_HYS) begin
      rexit_q <= found;
      rssth_q <= ssth_e;
      if (ss) begin
        mode_q <= MODE_SS;
      end else if (ack_q == '0) begin
        mode_q <= MODE_NONE;
      end else if (cwnd_q == '0) begin
        mode_q <= MODE_SQ;
      end else begin
        mode_q <= MODE_CA;
      end
    end
  end

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  twhs_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = s_axis_tuser ? S_LOSS : S_MUL0;
      S_LOSS: state_d = S_FIN;
      S_MUL0: state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_HYS;
      S_HYS:  state_d = need_div ? S_DIV : S_FIN;
      S_DIV:  if (div_rsp.done) state_d = S_FIN;
      S_FIN:  if (!m_axis_tvalid || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    unique case (state_q)
      S_MUL0:  mul_a = low_q;
      S_MUL2:  mul_a = ack_q;
      default: mul_a = seg_q;
    endcase
    div_req.start    = (state_q == S_HYS) && need_div;
    div_req.dividend = DvdW'(sq_q);
    div_req.divisor  = cwnd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // output register
  logic [DvdW-1:0] add;
  logic [DvdW:0]   sum;
  logic [WinW-1:0] cwnd_new;
  logic            ovalid_q;
  logic [WinW-1:0] ocwnd_q, ossth_q;
  logic            oexit_q;
  logic            load;

  always_comb begin
    unique case (mode_q)
      MODE_SS: add = DvdW'(ab_q) + DvdW'(fifth_q);
      MODE_SQ: add = DvdW'(sq_q);
      MODE_CA: add = (div_rsp.quotient == '0) ? DvdW'(1) : div_rsp.quotient;
      default: add = '0;
    endcase
    sum      = {1'b0, add} + (DvdW + 1)'(cwnd_q);
    cwnd_new = (sum > (DvdW + 1)'({WinW{1'b1}})) ? {WinW{1'b1}} : sum[WinW-1:0];
    load     = (state_q == S_FIN) && (!ovalid_q || m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (load) ovalid_q <= 1'b1;
    else if (m_axis_tready) ovalid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ocwnd_q <= cwnd_new;
      ossth_q <= rssth_q;
      oexit_q <= rexit_q;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {ossth_q, ocwnd_q};
  assign m_axis_tuser  = oexit_q;

  `TWHS_ASSERT(a_busy_not_ready, (state_q != S_IDLE) |-> !s_axis_tready, "ready while busy")
  `TWHS_ASSERT(a_div_in_wait, div_rsp.busy |-> (state_q == S_DIV), "divider runs outside wait")
  `TWHS_ASSERT(a_rise_from_fin, $rose(m_axis_tvalid) |-> ($past(state_q) == S_FIN),
               "result without a finished word")
  `TWHS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (state_q == S_IDLE || !rst_ni),
                      "sequencer not idle after reset")

endmodule
